@@ hw/rtl/url_dec_pkg.sv @@
// url_dec_pkg: transaction types, character constants and helper functions
// for the url percent decoder; shared by all files in hw/rtl
// no dependencies
package url_dec_pkg;

  // width of the capacity register
  localparam int unsigned CFG_W = 13;
  localparam logic [CFG_W-1:0] CAP_RESET = 13'd1024;

  // characters with special meaning
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_DEL     = 8'h7F;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_LF      = 8'h0A;
  localparam logic [7:0] CH_CR      = 8'h0D;

  // escape phase, one-hot
  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_HIGH = 3'b010,
    PH_LOW  = 3'b100
  } phase_e;

  // input transaction
  typedef struct packed {
    logic [7:0] src_byte;
    logic       is_last;
    logic       empty_string;
  } in_item_t;

  // result transaction
  typedef struct packed {
    logic       byte_valid;
    logic [7:0] out_byte;
    logic       done_res;
    logic       decode_ok;
  } out_item_t;

  // hex digit decode: bit 4 set when the character is a valid digit
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

  // decoded byte that is not allowed in the output
  function automatic logic bad_byte(input logic [7:0] v);
    logic ctrl;
    ctrl = (v < CH_SPACE) && (v != CH_TAB) && (v != CH_LF) && (v != CH_CR);
    return ctrl || (v == CH_DEL);
  endfunction

endpackage

@@ hw/rtl/url_dec_step.sv @@
// url_dec_step: per-string decode state and the combinational decode of one byte
// depends on url_dec_pkg
module url_dec_step
  import url_dec_pkg::*;
#(
  parameter int unsigned MaxCapacity = 4096,
  parameter int unsigned CntW        = 12
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fire_i,
  input  in_item_t         item_i,
  input  logic [CFG_W-1:0] capacity_i,
  output logic             has_result_o,
  output out_item_t        result_o
);

  localparam int unsigned CmpW = ((CntW > CFG_W) ? CntW : CFG_W) + 1;

  phase_e          phase_q, phase_d, phase_cur;
  logic [3:0]      high_q, high_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            fail_q, fail_d;

  logic [CmpW-1:0] cap_ext, cap_eff;
  logic [4:0]      hex;
  logic            have, done, ok;
  logic [7:0]      value;

  // effective capacity, clipped to the maximum
  assign cap_ext = CmpW'(capacity_i);
  assign cap_eff = (cap_ext > CmpW'(MaxCapacity)) ? CmpW'(MaxCapacity) : cap_ext;

  assign hex = hex_digit(item_i.src_byte);

  // unused phase codes act as outside an escape
  always_comb begin
    case (phase_q)
      PH_IDLE: phase_cur = PH_IDLE;
      PH_HIGH: phase_cur = PH_HIGH;
      PH_LOW:  phase_cur = PH_LOW;
      default: phase_cur = PH_IDLE;
    endcase
  end

  // decode one byte
  always_comb begin
    phase_d = phase_cur;
    high_d  = high_q;
    cnt_d   = cnt_q;
    fail_d  = fail_q;
    have    = 1'b0;
    value   = 8'h00;
    done    = 1'b0;
    ok      = 1'b0;
    if (item_i.empty_string) begin
      done = 1'b1;
      ok   = !fail_q && (phase_cur == PH_IDLE) && (cap_eff != '0);
    end else begin
      if (!fail_q) begin
        if (phase_cur == PH_IDLE) begin
          if (item_i.src_byte == CH_PERCENT) begin
            phase_d = PH_HIGH;
          end else begin
            value = (item_i.src_byte == CH_PLUS) ? CH_SPACE : item_i.src_byte;
            have  = 1'b1;
          end
        end else if (!hex[4]) begin
          fail_d = 1'b1;
        end else if (phase_cur == PH_HIGH) begin
          high_d  = hex[3:0];
          phase_d = PH_LOW;
        end else begin
          value   = {high_q, hex[3:0]};
          phase_d = PH_IDLE;
          have    = 1'b1;
        end
        // output checks: forbidden byte or no room before the terminator
        if (have) begin
          if (value == 8'h00 || bad_byte(value) ||
              (CmpW'(cnt_q) + CmpW'(1)) >= cap_eff) begin
            fail_d = 1'b1;
            have   = 1'b0;
            value  = 8'h00;
          end else begin
            cnt_d = cnt_q + CntW'(1);
          end
        end
      end
      if (item_i.is_last) begin
        done = 1'b1;
        ok   = !fail_d && (phase_d == PH_IDLE) && (cap_eff != '0);
      end
    end
  end

  assign has_result_o        = have || done;
  assign result_o.byte_valid = have;
  assign result_o.out_byte   = value;
  assign result_o.done_res   = done;
  assign result_o.decode_ok  = done && ok;

  // state update; end of string clears everything
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      high_q  <= 4'h0;
      cnt_q   <= '0;
      fail_q  <= 1'b0;
    end else if (fire_i) begin
      if (done) begin
        phase_q <= PH_IDLE;
        high_q  <= 4'h0;
        cnt_q   <= '0;
        fail_q  <= 1'b0;
      end else begin
        phase_q <= phase_d;
        high_q  <= high_d;
        cnt_q   <= cnt_d;
        fail_q  <= fail_d;
      end
    end
  end

endmodule

@@ hw/rtl/url_dec_out.sv @@
// url_dec_out: result register with valid/stall handshake toward the consumer
// depends on url_dec_pkg
module url_dec_out
  import url_dec_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      load_i,
  input  out_item_t item_i,
  output logic      ready_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  logic      valid_q;
  out_item_t item_q;

  // register can take a new transaction when empty or being drained
  assign ready_o = !valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && load_i) begin
      item_q <= item_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

endmodule

@@ hw/rtl/url_percent_decoder_top.sv @@
// url_percent_decoder_top: top level of the url percent decoder
// depends on url_dec_pkg, url_dec_step, url_dec_out
//
// Decodes a form or query string one byte per transaction: "%xx" becomes one
// byte, '+' becomes a space, and the transaction that ends the string (is_last
// or empty_string) carries the final ok status. Each byte passes an input
// register, combinational decode logic that also updates the per-string state,
// and a result register, and one byte is taken every cycle while the consumer
// keeps up; the single decode stage with its state update sets that rate. The
// capacity register is written through the cfg port, which is always ready,
// and must only be changed between strings.
module url_percent_decoder_top
  import url_dec_pkg::*;
#(
  parameter int unsigned MAX_CAPACITY = 4096
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  in_item_t         in_item_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output out_item_t        out_item_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [CFG_W-1:0] cfg_data_i
);

  localparam int unsigned CntW = (MAX_CAPACITY > 2) ? $clog2(MAX_CAPACITY) : 1;

  logic [CFG_W-1:0] cap_q;
  logic             in_valid_q;
  in_item_t         in_item_q;
  logic             has_result;
  out_item_t        result;
  logic             out_ready;
  logic             fire;

  // capacity register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      cap_q <= cfg_data_i;
    end
  end

  // input register advances when the decode stage can retire its transaction
  assign fire       = in_valid_q && (!has_result || out_ready);
  assign in_stall_o = in_valid_q && !fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_item_q <= in_item_i;
    end
  end

  // decode stage
  url_dec_step #(
    .MaxCapacity (MAX_CAPACITY),
    .CntW        (CntW)
  ) u_step (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (fire),
    .item_i       (in_item_q),
    .capacity_i   (cap_q),
    .has_result_o (has_result),
    .result_o     (result)
  );

  // result register
  url_dec_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (fire && has_result),
    .item_i      (result),
    .ready_o     (out_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

@@ verif/url_percent_decoder_top_tb.sv @@
`timescale 1ns / 100ps
// url_percent_decoder_top_tb: self-checking testbench for the url percent decoder
// depends on url_dec_pkg and url_percent_decoder_top from hw/rtl
module url_percent_decoder_top_tb;
  import url_dec_pkg::*;

  localparam int MAX_CAP     = 4096;
  localparam int HOLD_CYCLES = 300;
  localparam int IDLE_LIMIT  = 2000;
  localparam int PHASE_ITEMS = 185;
  localparam int N_PHASES    = 10;

  // one row of the directed table; res only counts where typed is set
  typedef struct packed {
    in_item_t  stim;
    logic      typed;
    logic      has_res;
    out_item_t res;
  } row_t;

  localparam out_item_t NO_RES   = '{1'b0, 8'h00, 1'b0, 1'b0};
  localparam out_item_t OK_END   = '{1'b0, 8'h00, 1'b1, 1'b1};
  localparam out_item_t FAIL_END = '{1'b0, 8'h00, 1'b1, 1'b0};

  localparam row_t [0:26] DIR_ROWS = '{
    '{'{8'h61, 1'b0, 1'b0}, 1'b1, 1'b1, '{1'b1, 8'h61, 1'b0, 1'b0}},
    '{'{CH_PLUS, 1'b0, 1'b0}, 1'b0, 1'b0, NO_RES},
    '{'{CH_PERCENT, 1'b0, 1'b0}, 1'b0, 1'b0, NO_RES},
    '{'{8'h66, 1'b0, 1'b0}, 1'b0, 1'b0, NO_RES},
    '{'{8'h46, 1'b0, 1'b0}, 1'b1, 1'b1, '{1'b1, 8'hFF, 1'b0, 1'b0}},
    '{'{CH_PERCENT, 1'b0, 1'b0}, 1'b0, 1'b0, NO_RES},
    '{'{8'h34, 1'b0, 1'b0}, 1'b0, 1'b0, NO_RES},
    '{'{8'h31, 1'b1, 1'b0}, 1'b0, 1'b0, NO_RES},
    '{'{8'h00, 1'b0, 1'b1}, 1'b1, 1'b1, OK_END},
    '{'{CH_PERCENT, 1'b0, 1'b0}, 1'b0, 1'b0, NO_RES},
    '{'{8'h30, 1'b0, 1'b0}, 1'b0, 1'b0, NO_RES},
    '{'{8'h30, 1'b1, 1'b0}, 1'b1, 1'b1, FAIL_END},
    '{'{CH_TAB, 1'b0, 1'b0}, 1'b0, 1'b0, NO_RES},
    '{'{CH_DEL, 1'b1, 1'b0}, 1'b1, 1'b1, FAIL_END},
    '{'{8'h01, 1'b1, 1'b0}, 1'b1, 1'b1, FAIL_END},
    '{'{CH_PERCENT, 1'b0, 1'b0}, 1'b0, 1'b0, NO_RES},
    '{'{8'h67, 1'b0, 1'b0}, 1'b1, 1'b0, NO_RES},
    '{'{8'h78, 1'b1, 1'b0}, 1'b1, 1'b1, FAIL_END},
    '{'{CH_PERCENT, 1'b0, 1'b0}, 1'b0, 1'b0, NO_RES},
    '{'{8'h34, 1'b1, 1'b0}, 1'b1, 1'b1, FAIL_END},
    '{'{CH_LF, 1'b0, 1'b0}, 1'b0, 1'b0, NO_RES},
    '{'{CH_CR, 1'b0, 1'b0}, 1'b0, 1'b0, NO_RES},
    '{'{8'h00, 1'b1, 1'b1}, 1'b1, 1'b1, OK_END},
    '{'{8'h00, 1'b1, 1'b0}, 1'b1, 1'b1, FAIL_END},
    '{'{8'hFF, 1'b1, 1'b0}, 1'b1, 1'b1, '{1'b1, 8'hFF, 1'b1, 1'b1}},
    '{'{CH_PERCENT, 1'b0, 1'b0}, 1'b0, 1'b0, NO_RES},
    '{'{8'hFF, 1'b0, 1'b1}, 1'b1, 1'b1, FAIL_END}
  };

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             in_valid  = 1'b0;
  in_item_t         in_item   = '0;
  logic             out_stall = 1'b0;
  logic             cfg_valid = 1'b0;
  logic [CFG_W-1:0] cfg_data  = '0;
  logic             in_stall_o;
  logic             out_valid_o;
  out_item_t        out_item_o;
  logic             cfg_ready_o;

  // predictor state: capacity register and per-string decode state
  logic [CFG_W-1:0] cap_reg;
  phase_e           esc_ph;
  logic [3:0]       hi_nib;
  int               n_written;
  bit               str_failed;

  out_item_t pending_decodes[$];
  in_item_t  string_items[$];
  bit        calm;
  bit        hold_req    = 1'b0;
  int        mismatches  = 0;
  int        n_items;
  int        n_strings;
  int        n_results   = 0;
  int        idle_cycles = 0;

  // clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  url_percent_decoder_top #(
    .MAX_CAPACITY(MAX_CAP)
  ) DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall),
    .out_item_o (out_item_o),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data)
  );

  task automatic report_mismatch(input string what, input int got_v, input int exp_v);
    mismatches++;
    $display("%0t mismatch %s: got %0h expected %0h", $time, what, got_v, exp_v);
  endtask

  // decode one input transaction; returns 1 when it produces a result
  function automatic bit decode_step(input in_item_t it, output out_item_t res);
    int         room;
    int         digit;
    logic [7:0] val;
    bit         got;
    bit         fin;
    room  = (cap_reg > MAX_CAP) ? MAX_CAP : int'(cap_reg);
    digit = -1;
    val   = 8'h00;
    got   = 1'b0;
    fin   = 1'b0;
    if (it.empty_string) begin
      fin = 1'b1;
    end else begin
      if (!str_failed) begin
        if (esc_ph == PH_IDLE) begin
          if (it.src_byte == CH_PERCENT) begin
            esc_ph = PH_HIGH;
          end else begin
            val = (it.src_byte == CH_PLUS) ? CH_SPACE : it.src_byte;
            got = 1'b1;
          end
        end else begin
          if (it.src_byte >= 8'h30 && it.src_byte <= 8'h39) begin
            digit = it.src_byte - 8'h30;
          end else if (it.src_byte >= 8'h41 && it.src_byte <= 8'h46) begin
            digit = it.src_byte - 8'h41 + 10;
          end else if (it.src_byte >= 8'h61 && it.src_byte <= 8'h66) begin
            digit = it.src_byte - 8'h61 + 10;
          end
          if (digit < 0) begin
            str_failed = 1'b1;
          end else if (esc_ph == PH_HIGH) begin
            hi_nib = digit[3:0];
            esc_ph = PH_LOW;
          end else begin
            val    = {hi_nib, digit[3:0]};
            esc_ph = PH_IDLE;
            got    = 1'b1;
          end
        end
        // forbidden bytes and a full buffer end the string as failed
        if (got) begin
          if (val == 8'h00 || val == CH_DEL || n_written + 1 >= room ||
              (val < CH_SPACE && val != CH_TAB && val != CH_LF && val != CH_CR)) begin
            str_failed = 1'b1;
            got        = 1'b0;
            val        = 8'h00;
          end else begin
            n_written++;
          end
        end
      end
      fin = it.is_last;
    end
    res.byte_valid = got;
    res.out_byte   = val;
    res.done_res   = fin;
    res.decode_ok  = fin && !str_failed && esc_ph == PH_IDLE && room != 0;
    if (fin) begin
      esc_ph     = PH_IDLE;
      hi_nib     = 4'h0;
      n_written  = 0;
      str_failed = 1'b0;
    end
    return got || fin;
  endfunction

  task automatic check_result(input out_item_t got);
    out_item_t want;
    n_results++;
    if (pending_decodes.size() == 0) begin
      report_mismatch("result with nothing expected", got, 0);
    end else begin
      want = pending_decodes.pop_front();
      if (got.byte_valid !== want.byte_valid)
        report_mismatch("byte_valid", got.byte_valid, want.byte_valid);
      if (got.out_byte !== want.out_byte)
        report_mismatch("out_byte", got.out_byte, want.out_byte);
      if (got.done_res !== want.done_res)
        report_mismatch("done_res", got.done_res, want.done_res);
      if (got.decode_ok !== want.decode_ok)
        report_mismatch("decode_ok", got.decode_ok, want.decode_ok);
    end
  endtask

  // offer one transaction after a random gap; predict once it is taken
  task automatic send_item(input in_item_t it, input bit typed, input bit typed_has,
                           input out_item_t typed_res);
    int        gap;
    bit        has;
    out_item_t res;
    gap = calm ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall_o) @(posedge clk);
    has = decode_step(it, res);
    if (typed) begin
      has = typed_has;
      res = typed_res;
    end
    if (has) pending_decodes.push_back(res);
    n_items++;
  endtask

  // stop offering, let every expected result arrive, then cover the latency
  task automatic wait_drain();
    in_valid <= 1'b0;
    while (pending_decodes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CFG_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready_o) @(posedge clk);
    cfg_valid <= 1'b0;
    cap_reg = v;
  endtask

  // hex digit character with random letter case
  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    if (nib < 4'd10) return 8'h30 + nib;
    return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + nib - 8'd10;
  endfunction

  // one encoded string, mostly well formed, with some noise and broken escapes
  task automatic gen_string();
    int         len;
    int         kind;
    logic [7:0] v;
    in_item_t   it;
    string_items.delete();
    it = '0;
    if ($urandom_range(0, 19) == 0) begin
      it.src_byte     = 8'($urandom_range(0, 255));
      it.is_last      = 1'($urandom_range(0, 1));
      it.empty_string = 1'b1;
      string_items.push_back(it);
    end else begin
      len = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 10);
      for (int i = 0; i < len; i++) begin
        kind = $urandom_range(0, 99);
        if (kind < 45) begin
          v = 8'($urandom_range(8'h20, 8'h7E));
          it.src_byte = (v == CH_PERCENT) ? CH_PLUS : v;
          string_items.push_back(it);
        end else if (kind < 55) begin
          it.src_byte = CH_PLUS;
          string_items.push_back(it);
        end else if (kind < 85) begin
          v = 8'($urandom_range(0, 1) ? $urandom_range(8'h20, 8'h7E) : $urandom_range(0, 255));
          it.src_byte = CH_PERCENT;
          string_items.push_back(it);
          it.src_byte = hex_char(v[7:4]);
          string_items.push_back(it);
          it.src_byte = hex_char(v[3:0]);
          string_items.push_back(it);
        end else if (kind < 90) begin
          it.src_byte = 8'($urandom_range(0, 255));
          string_items.push_back(it);
        end else if (kind < 94) begin
          it.src_byte = 8'($urandom_range(0, 8'h1F));
          string_items.push_back(it);
        end else if (kind < 97) begin
          it.src_byte = CH_PERCENT;
          string_items.push_back(it);
          it.src_byte = 8'($urandom_range(0, 255));
          string_items.push_back(it);
        end else begin
          it.src_byte = CH_PERCENT;
          string_items.push_back(it);
        end
      end
      // end by is_last on the final byte, sometimes by an empty marker
      if ($urandom_range(0, 9) == 0) begin
        it.src_byte     = 8'($urandom_range(0, 255));
        it.is_last      = 1'($urandom_range(0, 1));
        it.empty_string = 1'b1;
        string_items.push_back(it);
      end else begin
        string_items[string_items.size()-1].is_last = 1'b1;
      end
    end
    n_strings++;
  endtask

  // result side: random stall per transaction, plus one long hold on request
  initial begin : result_sink
    int stall_left;
    int hold_left;
    bit hold_taken;
    stall_left = 0;
    hold_left  = 0;
    hold_taken = 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid_o && !out_stall) begin
        check_result(out_item_o);
        stall_left = calm ? 0 : $urandom_range(0, 14);
      end
      if (hold_req && !hold_taken) begin
        hold_left  = HOLD_CYCLES;
        hold_taken = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall) ||
        (cfg_valid && cfg_ready_o)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout after %0d idle cycles", idle_cycles);
      $display("url_percent_decoder_top_tb: errors");
      $finish;
    end
  end

  // main sequence
  initial begin : stimulus
    logic [CFG_W-1:0] cap_val;
    int               phase_items;
    bit               held;
    cap_reg     = CAP_RESET;
    esc_ph      = PH_IDLE;
    hi_nib      = 4'h0;
    n_written   = 0;
    str_failed  = 1'b0;
    calm        = 1'b0;
    n_items     = 0;
    n_strings   = 0;
    held        = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table at the reset capacity
    for (int r = 0; r < $size(DIR_ROWS); r++) begin
      send_item(DIR_ROWS[r].stim, DIR_ROWS[r].typed, DIR_ROWS[r].has_res, DIR_ROWS[r].res);
    end
    wait_drain();

    // random strings over several capacity settings
    for (int p = 0; p < N_PHASES; p++) begin
      case (p)
        0:       cap_val = 13'd2;
        1:       cap_val = 13'd0;
        2:       cap_val = 13'd8191;
        3:       cap_val = 13'd1;
        4:       cap_val = 13'd4096;
        5:       cap_val = 13'd5;
        6:       cap_val = 13'd17;
        7:       cap_val = 13'($urandom_range(2, 40));
        8:       cap_val = 13'($urandom_range(0, 8191));
        default: cap_val = 13'd3;
      endcase
      write_capacity(cap_val);
      calm = (p == 2 || p == 6);
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        gen_string();
        foreach (string_items[k]) begin
          send_item(string_items[k], 1'b0, 1'b0, NO_RES);
          phase_items++;
          // hold the result side while the sender keeps offering
          if (p == 2 && !held && phase_items > 20) begin
            hold_req = 1'b1;
            held     = 1'b1;
          end
        end
      end
      wait_drain();
    end

    repeat (8) @(posedge clk);
    if (pending_decodes.size() != 0)
      report_mismatch("results never seen", pending_decodes.size(), 0);
    $display("summary: %0d items in %0d strings, %0d results checked", n_items, n_strings,
             n_results);
    $display("summary: %0d capacity settings incl. 0, 1 and above max, long output hold",
             N_PHASES + 1);
    if (mismatches == 0) begin
      $display("url_percent_decoder_top_tb: clean");
    end else begin
      $display("url_percent_decoder_top_tb: errors");
    end
    $finish;
  end

endmodule
